@@ rtl/rdd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rdd_pkg
// Shared types, constants and helper functions for the date check and
// day difference block.
// ----------------------------------------------------------------------------
package rdd_pkg;

    // Field widths.
    localparam int YearW   = 14;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int StatusW = 2;
    localparam int DiffW   = 23;
    localparam int DayNumW = 24;
    localparam int CfgIdxW = 1;

    // Status codes, in order of check precedence.
    localparam logic [StatusW-1:0] StatusOk       = 2'd0;
    localparam logic [StatusW-1:0] StatusYearBad  = 2'd1;
    localparam logic [StatusW-1:0] StatusMonthBad = 2'd2;
    localparam logic [StatusW-1:0] StatusDayBad   = 2'd3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgMinYear     = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgCurrentYear = 1'b1;

    // Register reset values.
    localparam logic [YearW-1:0] MinYearReset     = 14'd1500;
    localparam logic [YearW-1:0] CurrentYearReset = 14'd2021;

    // Saturation limits of the difference output.
    localparam logic signed [DayNumW:0] DiffMaxWide = 25'sd4194303;
    localparam logic signed [DayNumW:0] DiffMinWide = -25'sd4194304;
    localparam logic [DiffW-1:0]        DiffMax     = 23'h3FFFFF;
    localparam logic [DiffW-1:0]        DiffMin     = 23'h400000;

    // Per-date result handed from the date unit to the compare stage.
    typedef struct packed {
        logic [StatusW-1:0]        status;
        logic signed [DayNumW-1:0] day_num;
    } t_date_res;

    // Length of a month in a common year; meaningless codes give zero.
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
        logic [DayW-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the month in a March-based year, (153*m - 457) / 5,
    // where January and February (and month zero) count as months 13, 14
    // and 12 of the year before.
    function automatic logic [8:0] month_offset(input logic [MonthW-1:0] m);
        logic [8:0] off;
        case (m)
            4'd0:    off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd13:   off = 9'd306;
            4'd14:   off = 9'd337;
            4'd15:   off = 9'd367;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    // Quotient by 100 through a reciprocal multiply; exact for all 14-bit values.
    function automatic logic [7:0] div100(input logic [YearW-1:0] x);
        logic [26:0] prod;
        prod = 27'(x) * 27'd5243;
        return prod[26:19];
    endfunction

endpackage
`default_nettype wire

@@ rtl/date_validate_and_day_difference_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// date_validate_and_day_difference_top
// Checks two Gregorian dates and gives their day-number difference.
// ----------------------------------------------------------------------------
// Each transfer carries two dates. Both are checked (year window, then month,
// then day against the Gregorian month length) and converted to Rata Die day
// numbers; the result carries both status codes, the saturated difference
// A minus B and equal/earlier/later flags. The block takes one transfer every
// clock cycle while the output is not stalled. An accepted item is held in the
// input register while the date checks, conversions and compare are worked out
// in the logic after it; its result is captured in the result register and
// presented from there. Both registers may hold an item while the
// output is stalled. The year window registers are written through the
// plain configuration port and should only change while the block is empty.
// ----------------------------------------------------------------------------
module date_validate_and_day_difference_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration port
    input  wire logic                          i_cfg_we,
    input  wire logic [rdd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [rdd_pkg::YearW-1:0]     i_cfg_data,
    // Input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [rdd_pkg::YearW-1:0]     i_year_a,
    input  wire logic [rdd_pkg::MonthW-1:0]    i_month_a,
    input  wire logic [rdd_pkg::DayW-1:0]      i_day_a,
    input  wire logic [rdd_pkg::YearW-1:0]     i_year_b,
    input  wire logic [rdd_pkg::MonthW-1:0]    i_month_b,
    input  wire logic [rdd_pkg::DayW-1:0]      i_day_b,
    // Output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [rdd_pkg::StatusW-1:0]        o_status_a,
    output logic [rdd_pkg::StatusW-1:0]        o_status_b,
    output logic signed [rdd_pkg::DiffW-1:0]   o_day_difference,
    output logic                               o_dates_equal,
    output logic                               o_first_earlier,
    output logic                               o_first_later
);

    logic [rdd_pkg::YearW-1:0]  r_min_year;
    logic [rdd_pkg::YearW-1:0]  r_current_year;

    logic                       r_in_valid;
    logic [rdd_pkg::YearW-1:0]  r_year_a;
    logic [rdd_pkg::MonthW-1:0] r_month_a;
    logic [rdd_pkg::DayW-1:0]   r_day_a;
    logic [rdd_pkg::YearW-1:0]  r_year_b;
    logic [rdd_pkg::MonthW-1:0] r_month_b;
    logic [rdd_pkg::DayW-1:0]   r_day_b;

    logic                       r_out_valid;
    logic [rdd_pkg::StatusW-1:0] r_status_a;
    logic [rdd_pkg::StatusW-1:0] r_status_b;
    logic [rdd_pkg::DiffW-1:0]  r_diff;
    logic                       r_equal;
    logic                       r_earlier;
    logic                       r_later;

    logic                       out_adv;
    logic                       in_take;
    rdd_pkg::t_date_res         res_a;
    rdd_pkg::t_date_res         res_b;
    logic [rdd_pkg::DiffW-1:0]  n_diff;
    logic                       n_equal;
    logic                       n_earlier;
    logic                       n_later;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year     <= rdd_pkg::MinYearReset;
            r_current_year <= rdd_pkg::CurrentYearReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rdd_pkg::CfgMinYear:     r_min_year     <= i_cfg_data;
                rdd_pkg::CfgCurrentYear: r_current_year <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Flow control: the result register frees when empty or taken, and the
    // input register frees when empty or moving on.
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_adv;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || out_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_year_a  <= i_year_a;
            r_month_a <= i_month_a;
            r_day_a   <= i_day_a;
            r_year_b  <= i_year_b;
            r_month_b <= i_month_b;
            r_day_b   <= i_day_b;
        end
    end

    // Date checks and conversions.
    rdd_date_unit u_date_a (
        .i_year         (r_year_a),
        .i_month        (r_month_a),
        .i_day          (r_day_a),
        .i_min_year     (r_min_year),
        .i_current_year (r_current_year),
        .o_res          (res_a)
    );

    rdd_date_unit u_date_b (
        .i_year         (r_year_b),
        .i_month        (r_month_b),
        .i_day          (r_day_b),
        .i_min_year     (r_min_year),
        .i_current_year (r_current_year),
        .o_res          (res_b)
    );

    // Difference and ordering.
    rdd_compare u_compare (
        .i_num_a   (res_a.day_num),
        .i_num_b   (res_b.day_num),
        .o_diff    (n_diff),
        .o_equal   (n_equal),
        .o_earlier (n_earlier),
        .o_later   (n_later)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_status_a <= res_a.status;
            r_status_b <= res_b.status;
            r_diff     <= n_diff;
            r_equal    <= n_equal;
            r_earlier  <= n_earlier;
            r_later    <= n_later;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status_a       = r_status_a;
    assign o_status_b       = r_status_b;
    assign o_day_difference = r_diff;
    assign o_dates_equal    = r_equal;
    assign o_first_earlier  = r_earlier;
    assign o_first_later    = r_later;

endmodule
`default_nettype wire

@@ rtl/rdd_date_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rdd_date_unit
// Checks one date against the year window, the month range and the month
// length, and converts it to a Rata Die day number.
// ----------------------------------------------------------------------------
module rdd_date_unit (
    input  wire logic [rdd_pkg::YearW-1:0]  i_year,
    input  wire logic [rdd_pkg::MonthW-1:0] i_month,
    input  wire logic [rdd_pkg::DayW-1:0]   i_day,
    input  wire logic [rdd_pkg::YearW-1:0]  i_min_year,
    input  wire logic [rdd_pkg::YearW-1:0]  i_current_year,
    output rdd_pkg::t_date_res              o_res
);

    logic                                wrap;
    logic signed [rdd_pkg::YearW+1:0]    year_adj;
    logic [rdd_pkg::YearW-1:0]           year_pos;
    logic [rdd_pkg::YearW-3:0]           q4;
    logic [7:0]                          q100;
    logic [5:0]                          q400;
    logic signed [rdd_pkg::DayNumW-1:0]  year_days;
    logic signed [rdd_pkg::DayNumW-1:0]  day_num;
    logic [7:0]                          q100_raw;
    logic [rdd_pkg::YearW-1:0]           rem100;
    logic                                leap;
    logic [rdd_pkg::DayW-1:0]            len;
    logic                                year_bad;
    logic                                month_bad;
    logic                                day_bad;

    // January, February and month zero belong to the year before.
    assign wrap     = (i_month < 4'd3);
    assign year_adj = wrap ? ($signed({2'b00, i_year}) - 16'sd1)
                           : $signed({2'b00, i_year});
    // Only year zero can go negative, and its quotients all truncate to zero.
    assign year_pos = year_adj[rdd_pkg::YearW+1] ? '0 : year_adj[rdd_pkg::YearW-1:0];

    // Leap-year corrections from the adjusted year.
    assign q4   = year_pos[rdd_pkg::YearW-1:2];
    assign q100 = rdd_pkg::div100(year_pos);
    assign q400 = q100[7:2];

    // Day number: 365*y + y/4 - y/100 + y/400 + month offset + day - 306.
    assign year_days = $signed({{(rdd_pkg::DayNumW-rdd_pkg::YearW-2){year_adj[rdd_pkg::YearW+1]}},
                                year_adj}) * 24'sd365;
    assign day_num = year_days
                   + $signed(24'(q4))
                   - $signed(24'(q100))
                   + $signed(24'(q400))
                   + $signed(24'(rdd_pkg::month_offset(i_month)))
                   + $signed(24'(i_day))
                   - 24'sd306;

    // Gregorian leap rule on the year as given.
    assign q100_raw = rdd_pkg::div100(i_year);
    assign rem100   = i_year - (14'(q100_raw) * 14'd100);
    assign leap     = (i_year[1:0] == 2'b00) && ((rem100 != '0) || (q100_raw[1:0] == 2'b00));

    // Month length with the February leap day.
    assign len = rdd_pkg::month_len(i_month) + 5'((i_month == 4'd2) && leap);

    // Checks, first failure wins.
    assign year_bad  = (i_year < i_min_year) ||
                       ({1'b0, i_year} > ({1'b0, i_current_year} + 15'd1));
    assign month_bad = (i_month == 4'd0) || (i_month > 4'd12);
    assign day_bad   = (i_day == 5'd0) || (i_day > len);

    always_comb begin
        if (year_bad) begin
            o_res.status = rdd_pkg::StatusYearBad;
        end else if (month_bad) begin
            o_res.status = rdd_pkg::StatusMonthBad;
        end else if (day_bad) begin
            o_res.status = rdd_pkg::StatusDayBad;
        end else begin
            o_res.status = rdd_pkg::StatusOk;
        end
        o_res.day_num = day_num;
    end

endmodule
`default_nettype wire

@@ rtl/rdd_compare.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rdd_compare
// Subtracts the two day numbers, saturates the difference to the output
// range and derives the ordering flags from the full-width day numbers.
// ----------------------------------------------------------------------------
module rdd_compare (
    input  wire logic signed [rdd_pkg::DayNumW-1:0] i_num_a,
    input  wire logic signed [rdd_pkg::DayNumW-1:0] i_num_b,
    output logic [rdd_pkg::DiffW-1:0]               o_diff,
    output logic                                    o_equal,
    output logic                                    o_earlier,
    output logic                                    o_later
);

    logic signed [rdd_pkg::DayNumW:0] diff;

    // Full difference with one guard bit.
    assign diff = $signed({i_num_a[rdd_pkg::DayNumW-1], i_num_a})
                - $signed({i_num_b[rdd_pkg::DayNumW-1], i_num_b});

    // Clamp to the output range.
    always_comb begin
        if (diff > rdd_pkg::DiffMaxWide) begin
            o_diff = rdd_pkg::DiffMax;
        end else if (diff < rdd_pkg::DiffMinWide) begin
            o_diff = rdd_pkg::DiffMin;
        end else begin
            o_diff = diff[rdd_pkg::DiffW-1:0];
        end
    end

    // Ordering flags.
    assign o_equal   = (i_num_a == i_num_b);
    assign o_earlier = (i_num_a < i_num_b);
    assign o_later   = (i_num_a > i_num_b);

endmodule
`default_nettype wire
